// File: rtl/hmf_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the HTTP message framer.
// No dependencies; every other file of the framer imports this package.
package hmf_pkg;

    localparam int HMF_LINE_LIMIT  = 256;
    localparam int HMF_LENGTH_BITS = 16;
    localparam int HMF_QUEUE_DEPTH = 4;
    localparam int MAX_RESULTS     = 3;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;

    // Length of "CONTENT-LENGTH:"
    localparam logic [3:0] PREFIX_LEN = 4'd15;

    typedef enum logic [2:0] {
        PH_REQUEST    = 3'd0,
        PH_HEADER     = 3'd1,
        PH_SKIP_NL    = 3'd2,
        PH_CONTENT_NL = 3'd3,
        PH_BODY       = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        NP_PREFIX   = 3'd0,
        NP_SPACES   = 3'd1,
        NP_DIGITS   = 3'd2,
        NP_NEGATIVE = 3'd3,
        NP_ENDED    = 3'd4,
        NP_NOMATCH  = 3'd5
    } nphase_t;

    typedef enum logic [2:0] {
        EV_LINE_BYTE  = 3'd0,
        EV_REQ_END    = 3'd1,
        EV_HDR_END    = 3'd2,
        EV_BODY_START = 3'd3,
        EV_BODY_BYTE  = 3'd4,
        EV_MSG_END    = 3'd5,
        EV_MISSING    = 3'd6
    } event_t;

    typedef struct packed {
        event_t      ev;
        logic [7:0]  data;
        logic [8:0]  len;
        logic [15:0] clen;
    } result_t;

    // All results caused by one accepted byte, res[0] first.
    typedef struct packed {
        logic [1:0]                    cnt;
        result_t [MAX_RESULTS-1:0]     res;
    } bundle_t;

    function automatic logic [7:0] prefix_char(input logic [3:0] pos);
        logic [7:0] c;
        unique case (pos)
            4'd0:    c = 8'h43; // C
            4'd1:    c = 8'h4F; // O
            4'd2:    c = 8'h4E; // N
            4'd3:    c = 8'h54; // T
            4'd4:    c = 8'h45; // E
            4'd5:    c = 8'h4E; // N
            4'd6:    c = 8'h54; // T
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h4C; // L
            4'd9:    c = 8'h45; // E
            4'd10:   c = 8'h4E; // N
            4'd11:   c = 8'h47; // G
            4'd12:   c = 8'h54; // T
            4'd13:   c = 8'h48; // H
            4'd14:   c = 8'h3A; // :
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/hmf_front.sv
`timescale 1ns / 1ps
// Front end: connection tracking, line splitter, length matcher and body counter.
// Pushes one result bundle for each accepted byte that causes a result. Depends on hmf_pkg.
module hmf_front
    import hmf_pkg::*;
#(
    parameter int LINE_LIMIT  = HMF_LINE_LIMIT,
    parameter int LENGTH_BITS = HMF_LENGTH_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_fire,
    input  logic        command,
    input  logic [7:0]  data_byte,
    input  logic        frame_first,
    input  logic [31:0] peer_address,
    input  logic [31:0] peer_ports,
    output logic        push,
    output bundle_t     push_bundle
);

    localparam int LC_W = $clog2(LINE_LIMIT + 1);
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    phase_t                  phase_reg, phase_next;
    nphase_t                 np_reg, np_next;
    logic                    busy_reg, busy_next;
    logic [63:0]             key_reg, key_next;
    logic [LC_W-1:0]         lc_reg, lc_next;
    logic [LENGTH_BITS-1:0]  bl_reg, bl_next;
    logic [LENGTH_BITS-1:0]  bc_reg, bc_next;
    logic [3:0]              pp_reg, pp_next;
    logic [LENGTH_BITS-1:0]  nv_reg, nv_next;

    logic                    do_line, do_body, entry_b;
    logic                    is_digit, is_blank;
    logic [7:0]              upper;
    logic [LENGTH_BITS+3:0]  nv4, prod;
    event_t                  line_ev;
    bundle_t                 bnd;

    function automatic logic [15:0] clen16(input logic [LENGTH_BITS-1:0] v);
        logic [LENGTH_BITS+15:0] e;
        e = {16'd0, v};
        return e[15:0];
    endfunction

    function automatic logic [8:0] len9(input logic [LC_W-1:0] v);
        logic [LC_W+8:0] e;
        e = {9'd0, v};
        return e[8:0];
    endfunction

    function automatic bundle_t put(input bundle_t bi, input event_t ev,
                                    input logic [7:0] d, input logic [8:0] ln,
                                    input logic [15:0] cl);
        bundle_t bo;
        result_t r;
        bo     = bi;
        r.ev   = ev;
        r.data = d;
        r.len  = ln;
        r.clen = cl;
        case (bi.cnt)
            2'd0:    bo.res[0] = r;
            2'd1:    bo.res[1] = r;
            2'd2:    bo.res[2] = r;
            default: ;
        endcase
        bo.cnt = bi.cnt + 2'd1;
        return bo;
    endfunction

    assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    assign is_blank = (data_byte == CH_SPACE) || (data_byte == CH_TAB) ||
                      (data_byte == CH_VT) || (data_byte == CH_FF);
    assign upper    = ((data_byte >= CH_LC_A) && (data_byte <= CH_LC_Z)) ?
                      (data_byte - 8'd32) : data_byte;

    always_comb
    begin
        phase_next = phase_reg;
        np_next    = np_reg;
        busy_next  = busy_reg;
        key_next   = key_reg;
        lc_next    = lc_reg;
        bl_next    = bl_reg;
        bc_next    = bc_reg;
        pp_next    = pp_reg;
        nv_next    = nv_reg;
        bnd        = '0;
        do_line    = 1'b0;
        do_body    = 1'b0;
        entry_b    = 1'b0;
        line_ev    = EV_REQ_END;
        nv4        = '0;
        prod       = '0;

        if (command)
        begin
            busy_next = 1'b0;
        end
        else if (frame_first || busy_reg)
        begin
            // New peer or idle connection: restart the parser
            if (frame_first && (!busy_reg || ({peer_address, peer_ports} != key_reg)))
            begin
                busy_next  = 1'b1;
                key_next   = {peer_address, peer_ports};
                phase_next = PH_REQUEST;
                lc_next    = '0;
                bl_next    = '0;
                bc_next    = '0;
                pp_next    = '0;
                np_next    = NP_PREFIX;
                nv_next    = '0;
            end

            unique case (phase_next) inside
                PH_REQUEST, PH_HEADER:
                begin
                    do_line = 1'b1;
                end
                PH_SKIP_NL:
                begin
                    phase_next = PH_HEADER;
                    do_line    = (data_byte != CH_LF);
                end
                PH_CONTENT_NL:
                begin
                    // Body start deferred from a blank CR line
                    bnd        = put(bnd, EV_BODY_START, 8'd0, 9'd0, clen16(bl_next));
                    phase_next = PH_BODY;
                    bc_next    = '0;
                    if (bl_next == '0)
                    begin
                        bnd        = put(bnd, EV_MSG_END, 8'd0, 9'd0, clen16(bl_next));
                        phase_next = PH_REQUEST;
                        lc_next    = '0;
                        bl_next    = '0;
                        pp_next    = '0;
                        np_next    = NP_PREFIX;
                        nv_next    = '0;
                    end
                    if (data_byte != CH_LF)
                    begin
                        if (phase_next == PH_BODY)
                            do_body = 1'b1;
                        else
                            do_line = 1'b1;
                    end
                end
                PH_BODY:
                begin
                    do_body = 1'b1;
                end
                default:
                begin
                    phase_next = PH_REQUEST;
                    do_line    = 1'b1;
                end
            endcase

            if (do_line)
            begin
                if ((data_byte == CH_CR) || (data_byte == CH_LF))
                begin
                    if (lc_next == '0)
                    begin
                        if (phase_next == PH_REQUEST)
                            bnd = put(bnd, EV_MISSING, 8'd0, 9'd0, clen16(bl_next));
                        else if (data_byte == CH_CR)
                            phase_next = PH_CONTENT_NL;
                        else
                            entry_b = 1'b1;
                    end
                    else
                    begin
                        line_ev = EV_REQ_END;
                        if (phase_next == PH_HEADER)
                        begin
                            line_ev = EV_HDR_END;
                            if ((np_next == NP_SPACES) || (np_next == NP_DIGITS) ||
                                (np_next == NP_NEGATIVE) || (np_next == NP_ENDED))
                                bl_next = (np_next == NP_NEGATIVE) ? '0 : nv_next;
                        end
                        bnd        = put(bnd, line_ev, 8'd0, len9(lc_next), clen16(bl_next));
                        phase_next = (data_byte == CH_CR) ? PH_SKIP_NL : PH_HEADER;
                    end
                    lc_next = '0;
                    pp_next = '0;
                    np_next = NP_PREFIX;
                    nv_next = '0;
                end
                else if (lc_next < LC_W'(LINE_LIMIT))
                begin
                    lc_next = lc_next + 1'b1;
                    if (phase_next == PH_HEADER)
                    begin
                        unique case (np_next)
                            NP_PREFIX:
                            begin
                                if ((pp_next < PREFIX_LEN) && (upper == prefix_char(pp_next)))
                                begin
                                    pp_next = pp_next + 4'd1;
                                    if (pp_next == PREFIX_LEN)
                                        np_next = NP_SPACES;
                                end
                                else
                                begin
                                    np_next = NP_NOMATCH;
                                end
                            end
                            NP_SPACES:
                            begin
                                if (!is_blank)
                                begin
                                    if (data_byte == CH_PLUS)
                                        np_next = NP_DIGITS;
                                    else if (data_byte == CH_MINUS)
                                        np_next = NP_NEGATIVE;
                                    else if (is_digit)
                                    begin
                                        np_next = NP_DIGITS;
                                        nv_next = {{(LENGTH_BITS-4){1'b0}}, data_byte[3:0]};
                                    end
                                    else
                                        np_next = NP_ENDED;
                                end
                            end
                            NP_DIGITS:
                            begin
                                if (is_digit)
                                begin
                                    nv4  = {4'd0, nv_next};
                                    prod = (nv4 << 3) + (nv4 << 1) +
                                           {{LENGTH_BITS{1'b0}}, data_byte[3:0]};
                                    nv_next = (prod > {4'd0, LEN_MAX}) ?
                                              LEN_MAX : prod[LENGTH_BITS-1:0];
                                end
                                else
                                begin
                                    np_next = NP_ENDED;
                                end
                            end
                            default: ;
                        endcase
                    end
                    bnd = put(bnd, EV_LINE_BYTE, data_byte, 9'd0, clen16(bl_next));
                end
            end

            if (entry_b)
            begin
                bnd        = put(bnd, EV_BODY_START, 8'd0, 9'd0, clen16(bl_next));
                phase_next = PH_BODY;
                bc_next    = '0;
                if (bl_next == '0)
                begin
                    bnd        = put(bnd, EV_MSG_END, 8'd0, 9'd0, clen16(bl_next));
                    phase_next = PH_REQUEST;
                    lc_next    = '0;
                    bl_next    = '0;
                    pp_next    = '0;
                    np_next    = NP_PREFIX;
                    nv_next    = '0;
                end
            end

            if (do_body)
            begin
                if (bc_next < bl_next)
                begin
                    bnd     = put(bnd, EV_BODY_BYTE, data_byte, 9'd0, clen16(bl_next));
                    bc_next = bc_next + 1'b1;
                end
                if (bc_next >= bl_next)
                begin
                    bnd        = put(bnd, EV_MSG_END, 8'd0, 9'd0, clen16(bl_next));
                    phase_next = PH_REQUEST;
                    lc_next    = '0;
                    bl_next    = '0;
                    bc_next    = '0;
                    pp_next    = '0;
                    np_next    = NP_PREFIX;
                    nv_next    = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_REQUEST;
            np_reg    <= NP_PREFIX;
            busy_reg  <= 1'b0;
            key_reg   <= '0;
            lc_reg    <= '0;
            bl_reg    <= '0;
            bc_reg    <= '0;
            pp_reg    <= '0;
            nv_reg    <= '0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            np_reg    <= np_next;
            busy_reg  <= busy_next;
            key_reg   <= key_next;
            lc_reg    <= lc_next;
            bl_reg    <= bl_next;
            bc_reg    <= bc_next;
            pp_reg    <= pp_next;
            nv_reg    <= nv_next;
        end
    end

    assign push        = in_fire && (bnd.cnt != 2'd0);
    assign push_bundle = bnd;

endmodule

// File: rtl/hmf_queue.sv
`timescale 1ns / 1ps
// Small register FIFO of result bundles between front and back.
// Depends on hmf_pkg.
module hmf_queue
    import hmf_pkg::*;
#(
    parameter int DEPTH = HMF_QUEUE_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t push_data,
    output logic    full,
    input  logic    pop,
    output bundle_t pop_data,
    output logic    empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bundle_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: rtl/hmf_back.sv
`timescale 1ns / 1ps
// Back end: holds one bundle and hands out its results one per transaction.
// Depends on hmf_pkg.
module hmf_back
    import hmf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_empty,
    input  bundle_t q_data,
    output logic    q_pop,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result,
    output logic    out_last
);

    bundle_t     bundle_reg;
    logic [1:0]  idx_reg, idx_next;
    logic        have_reg, have_next;
    logic        done;

    assign out_valid = have_reg;
    assign out_last  = (idx_reg == (bundle_reg.cnt - 2'd1));
    assign done      = !have_reg || (out_ready && out_last);
    assign q_pop     = done && !q_empty;

    always_comb
    begin
        case (idx_reg)
            2'd1:    out_result = bundle_reg.res[1];
            2'd2:    out_result = bundle_reg.res[2];
            default: out_result = bundle_reg.res[0];
        endcase
    end

    always_comb
    begin
        idx_next  = idx_reg;
        have_next = have_reg;
        if (done)
        begin
            have_next = !q_empty;
            idx_next  = 2'd0;
        end
        else if (out_ready)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= 2'd0;
            have_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            have_reg <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            bundle_reg <= q_data;
    end

endmodule

// File: rtl/http_message_framer_unit.sv
`timescale 1ns / 1ps
// Top level of the HTTP message framer: front end, bundle queue and back end.
// Depends on hmf_pkg, hmf_front, hmf_queue and hmf_back.

// The framer takes one received payload byte per transaction and turns it into
// zero to three result transactions (line bytes, line ends, body start, body
// bytes, message end, missing request line). The front end accepts a byte every
// cycle as long as the bundle queue (QUEUE_DEPTH entries, 4 by default) has
// room; all parsing of one byte is settled in that cycle. Its results pass
// through the queue and the back end's bundle register to the output and leave
// at one result per cycle while out_ready is high; bytes that cause no result
// (release commands, dropped bytes) put nothing into the queue.
// Reset leaves the connection idle: the next byte must open a frame.
module http_message_framer_unit
    import hmf_pkg::*;
#(
    parameter int LINE_LIMIT  = HMF_LINE_LIMIT,
    parameter int LENGTH_BITS = HMF_LENGTH_BITS,
    parameter int QUEUE_DEPTH = HMF_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    // byte channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [7:0]  data_byte,
    input  logic        frame_first,
    input  logic [31:0] peer_address,
    input  logic [31:0] peer_ports,
    input  logic [7:0]  protocol_number,   // carried with the frame, not needed for framing
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  event_res,
    output logic [7:0]  data_byte_out,
    output logic [8:0]  line_length,
    output logic [15:0] content_length,
    output logic        last
);

    logic     in_fire;
    logic     push, q_full, q_empty, q_pop;
    bundle_t  push_bundle, q_data;
    result_t  out_result;

    // Stall input only on a full queue; state advances on every accepted byte
    assign in_ready = !q_full;
    assign in_fire  = in_valid && in_ready;

    hmf_front #(
        .LINE_LIMIT  (LINE_LIMIT),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_fire      (in_fire),
        .command      (command),
        .data_byte    (data_byte),
        .frame_first  (frame_first),
        .peer_address (peer_address),
        .peer_ports   (peer_ports),
        .push         (push),
        .push_bundle  (push_bundle)
    );

    hmf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_bundle),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    hmf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_data     (q_data),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_result (out_result),
        .out_last   (last)
    );

    assign event_res      = out_result.ev;
    assign data_byte_out  = out_result.data;
    assign line_length    = out_result.len;
    assign content_length = out_result.clen;

    // A bundle never stops short of its last result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid)
        else $error("result bundle ended without last");

    // Only line and body bytes carry data
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !(event_res == EV_LINE_BYTE || event_res == EV_BODY_BYTE)
        |-> data_byte_out == 8'd0)
        else $error("data on a non-byte event");

    // Only line ends carry a line length
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !(event_res == EV_REQ_END || event_res == EV_HDR_END)
        |-> line_length == 9'd0)
        else $error("line length on a non-line-end event");

    // A line end always reports a non-empty line
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == EV_REQ_END || event_res == EV_HDR_END)
        |-> line_length != 9'd0)
        else $error("empty line reported as line end");

endmodule
